### hw/rtl/slfd_pkg.sv
// Shared types and constants for the sync/length frame deframer.
// Holds the item and result word structs, register indexes, result kinds and phase codes.
// No dependencies.
package slfd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_FIRST      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_SECOND     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DATA_LENGTH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COMMS_TYPE_CODE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_LIMIT   = 3'd4;

    localparam logic [7:0]  SYNC_FIRST_RESET      = 8'd170;
    localparam logic [7:0]  SYNC_SECOND_RESET     = 8'd85;
    localparam logic [7:0]  MAX_DATA_LENGTH_RESET = 8'd255;
    localparam logic [7:0]  COMMS_TYPE_CODE_RESET = 8'd0;
    localparam logic [15:0] TIMEOUT_LIMIT_RESET   = 16'd500;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_ABORT   = 2'd2;

    typedef enum logic [5:0] {
        PH_HUNT   = 6'b000001,
        PH_SYNC2  = 6'b000010,
        PH_LEN    = 6'b000100,
        PH_DATA   = 6'b001000,
        PH_CRC_LO = 6'b010000,
        PH_CRC_HI = 6'b100000
    } phase_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_value;
    } item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  payload_value;
        logic [15:0] crc_received;
    } result_t;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [7:0]  max_data_length;
        logic [7:0]  comms_type_code;
        logic [15:0] timeout_limit;
    } cfg_t;

endpackage

### hw/rtl/slfd_cfg.sv
// Configuration register bank for the frame deframer.
// Depends on slfd_pkg for the register indexes, reset values and cfg_t.
module slfd_cfg
    import slfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first      <= SYNC_FIRST_RESET;
            cfg_reg.sync_second     <= SYNC_SECOND_RESET;
            cfg_reg.max_data_length <= MAX_DATA_LENGTH_RESET;
            cfg_reg.comms_type_code <= COMMS_TYPE_CODE_RESET;
            cfg_reg.timeout_limit   <= TIMEOUT_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SYNC_FIRST:      cfg_reg.sync_first      <= cfg_data[7:0];
                REG_SYNC_SECOND:     cfg_reg.sync_second     <= cfg_data[7:0];
                REG_MAX_DATA_LENGTH: cfg_reg.max_data_length <= cfg_data[7:0];
                REG_COMMS_TYPE_CODE: cfg_reg.comms_type_code <= cfg_data[7:0];
                REG_TIMEOUT_LIMIT:   cfg_reg.timeout_limit   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/slfd_core.sv
// Frame phase machine for the deframer: sync hunt, length check, data, CRC, timeout.
// Depends on slfd_pkg for phase_t, item_t, result_t and cfg_t.
module slfd_core
    import slfd_pkg::*;
#(
    parameter int TIMER_WIDTH = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  item_t   item,
    input  cfg_t    cfg,
    output logic    emit,
    output result_t result
);

    localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

    phase_t                 phase_reg, phase_next;
    logic [7:0]             frame_length_reg, frame_length_next;
    logic [7:0]             bytes_seen_reg, bytes_seen_next;
    logic [TIMER_WIDTH-1:0] tick_count_reg, tick_count_next;
    logic                   forwarding_reg, forwarding_next;
    logic                   payload_started_reg, payload_started_next;
    logic [7:0]             crc_low_byte_reg, crc_low_byte_next;

    logic [TIMER_WIDTH-1:0] tick_inc;
    logic [7:0]             seen_inc;
    logic                   timed_out;

    assign tick_inc  = (tick_count_reg != '1) ? tick_count_reg + 1'b1 : tick_count_reg;
    assign timed_out = CMP_W'(tick_inc) >= CMP_W'(cfg.timeout_limit);
    assign seen_inc  = bytes_seen_reg + 8'd1;

    always_comb
    begin
        phase_next           = phase_reg;
        frame_length_next    = frame_length_reg;
        bytes_seen_next      = bytes_seen_reg;
        tick_count_next      = tick_count_reg;
        forwarding_next      = forwarding_reg;
        payload_started_next = payload_started_reg;
        crc_low_byte_next    = crc_low_byte_reg;
        emit                 = 1'b0;
        result               = '0;

        unique case (phase_reg) inside
            PH_HUNT:
            begin
                if (item.cmd == CMD_BYTE && item.rx_value == cfg.sync_first)
                begin
                    phase_next      = PH_SYNC2;
                    tick_count_next = '0;
                end
            end
            PH_SYNC2, PH_LEN, PH_DATA, PH_CRC_LO, PH_CRC_HI:
            begin
                if (item.cmd == CMD_TICK)
                begin
                    tick_count_next = tick_inc;
                    if (timed_out)
                    begin
                        // back to hunt; abort only if payload already went out
                        phase_next           = PH_HUNT;
                        tick_count_next      = '0;
                        frame_length_next    = '0;
                        bytes_seen_next      = '0;
                        forwarding_next      = 1'b0;
                        payload_started_next = 1'b0;
                        crc_low_byte_next    = '0;
                        if (payload_started_reg)
                        begin
                            emit               = 1'b1;
                            result.result_kind = KIND_ABORT;
                        end
                    end
                end
                else
                begin
                    unique case (phase_reg)
                        PH_SYNC2:
                        begin
                            phase_next      = (item.rx_value == cfg.sync_second) ? PH_LEN : PH_HUNT;
                            tick_count_next = '0;
                            if (item.rx_value != cfg.sync_second)
                            begin
                                frame_length_next    = '0;
                                bytes_seen_next      = '0;
                                forwarding_next      = 1'b0;
                                payload_started_next = 1'b0;
                                crc_low_byte_next    = '0;
                            end
                        end
                        PH_LEN:
                        begin
                            tick_count_next      = '0;
                            bytes_seen_next      = '0;
                            forwarding_next      = 1'b0;
                            payload_started_next = 1'b0;
                            if (item.rx_value != 8'd0 && item.rx_value <= cfg.max_data_length)
                            begin
                                phase_next        = PH_DATA;
                                frame_length_next = item.rx_value;
                            end
                            else
                            begin
                                phase_next        = PH_HUNT;
                                frame_length_next = '0;
                                crc_low_byte_next = '0;
                            end
                        end
                        PH_DATA:
                        begin
                            if (bytes_seen_reg == 8'd0)
                            begin
                                // type byte decides whether the rest is forwarded
                                forwarding_next = (item.rx_value == cfg.comms_type_code)
                                                  && (frame_length_reg >= 8'd2);
                            end
                            else if (forwarding_reg)
                            begin
                                payload_started_next = 1'b1;
                                emit                 = 1'b1;
                                result.result_kind   = KIND_PAYLOAD;
                                result.payload_value = item.rx_value;
                            end
                            bytes_seen_next = seen_inc;
                            if (seen_inc >= frame_length_reg)
                            begin
                                phase_next      = PH_CRC_LO;
                                tick_count_next = '0;
                            end
                        end
                        PH_CRC_LO:
                        begin
                            crc_low_byte_next = item.rx_value;
                            phase_next        = PH_CRC_HI;
                        end
                        default:
                        begin
                            emit                 = 1'b1;
                            result.result_kind   = KIND_END;
                            result.crc_received  = {item.rx_value, crc_low_byte_reg};
                            phase_next           = PH_HUNT;
                            tick_count_next      = '0;
                            frame_length_next    = '0;
                            bytes_seen_next      = '0;
                            forwarding_next      = 1'b0;
                            payload_started_next = 1'b0;
                            crc_low_byte_next    = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                // stray code: recover to hunt
                phase_next           = PH_HUNT;
                tick_count_next      = '0;
                frame_length_next    = '0;
                bytes_seen_next      = '0;
                forwarding_next      = 1'b0;
                payload_started_next = 1'b0;
                crc_low_byte_next    = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_HUNT;
            frame_length_reg    <= '0;
            bytes_seen_reg      <= '0;
            tick_count_reg      <= '0;
            forwarding_reg      <= 1'b0;
            payload_started_reg <= 1'b0;
            crc_low_byte_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg           <= phase_next;
            frame_length_reg    <= frame_length_next;
            bytes_seen_reg      <= bytes_seen_next;
            tick_count_reg      <= tick_count_next;
            forwarding_reg      <= forwarding_next;
            payload_started_reg <= payload_started_next;
            crc_low_byte_reg    <= crc_low_byte_next;
        end
    end

endmodule

### hw/rtl/slfd_out.sv
// Result word register for the frame deframer; holds a result until the downstream side takes it.
// Depends on slfd_pkg for result_t.
module slfd_out
    import slfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    output logic    space,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign space      = !valid_reg || result_ready;
    assign valid_next = load || (valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

### hw/rtl/sync_length_frame_deframer.sv
// Top level of the sync/length frame deframer.
// Depends on slfd_pkg, slfd_cfg, slfd_core and slfd_out.
//
// Takes one word per cycle when ready, either a received byte or a timer tick, and walks the frame
// format: two sync bytes, a length byte (1..max_data_length), that many data bytes and two
// CRC bytes. The first data byte is a type; when it matches comms_type_code and the length
// is at least 2, each later data byte leaves as a payload result. The second CRC byte always
// gives a frame-end result carrying the raw CRC (first byte low); the CRC is not checked.
// Ticks in any frame phase advance a saturating TIMER_WIDTH-bit counter that restarts on
// entry into the second-sync, length, data and CRC phases (the two CRC bytes share one
// count); reaching timeout_limit drops back to hunting and gives an abort
// result if payload had already been sent. The phase machine updates at the accept edge and
// any result lands in a single output register, so the input is ready whenever that
// register is empty or being drained the same cycle. Sustained rate is one word per cycle
// while the result side keeps up. Write configuration only while idle.
module sync_length_frame_deframer
    import slfd_pkg::*;
#(
    parameter int TIMER_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg;
    logic    accept;
    logic    emit;
    result_t core_result;
    logic    space;

    // accept a word whenever the result register can take whatever it produces
    assign item_ready = space;
    assign accept     = item_valid && item_ready;

    slfd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    slfd_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg),
        .emit   (emit),
        .result (core_result)
    );

    // load a result only for accepted words that produce one
    slfd_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept && emit),
        .load_data    (core_result),
        .space        (space),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
